// ===== hdl/scbpa_pkg.sv =====
// Shared types, codes and helper functions of the size-class block pool allocator.
package scbpa_pkg;

  // Fixed dimensions
  localparam int MAX_CLASSES   = 7;
  localparam int MAX_SLOTS     = 32;
  localparam int SMALL_END     = 3;   // classes below this are small
  localparam int MEDIUM_END    = 5;   // classes below this (and not small) are medium
  localparam int SIZE_W        = 20;
  localparam int STRIDE_W      = 21;
  localparam int OFFSET_W      = 24;
  localparam int CLASS_W       = 3;
  localparam int SLOT_W        = 5;
  localparam int STATUS_W      = 3;
  localparam int OP_W          = 2;
  localparam int Q_DEPTH       = 2;

  localparam logic [OFFSET_W-1:0] HDR_BYTES = 24'd4;
  localparam logic [CLASS_W-1:0]  NO_CLASS  = 3'd7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

  // Command kinds handed from front to back
  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_FREE  = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;
  localparam logic [1:0] K_REPLY = 2'd3;  // answer known up front, no state change

  typedef struct packed {
    logic [1:0]          kind;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  cls;
    logic [STRIDE_W-1:0] stride;
    logic [OFFSET_W-1:0] foff;
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] block_offset;
    logic [SLOT_W-1:0]   slot_index;
    logic [CLASS_W-1:0]  class_id;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Block size of each class after reset
  function automatic logic [SIZE_W-1:0] reset_size(input int c);
    logic [SIZE_W-1:0] s;
    unique case (c)
      0:       s = 20'd64;
      1:       s = 20'd128;
      2:       s = 20'd512;
      3:       s = 20'd1024;
      4:       s = 20'd10240;
      5:       s = 20'd102400;
      default: s = 20'd307200;
    endcase
    return s;
  endfunction

  // Slot stride: block size rounded up to four bytes plus the header
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] b);
    logic [STRIDE_W-1:0] t;
    t = {1'b0, b} + 21'd3;
    return {t[STRIDE_W-1:2], 2'b00} + 21'd4;
  endfunction

endpackage

// ===== hdl/scbpa_front.sv =====
// Front end: size registers, item decode and class selection.
module scbpa_front #(
  parameter int NUM_CLASSES = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [scbpa_pkg::SIZE_W-1:0]   cfg_data,
  // decoded input beat
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scbpa_pkg::OP_W-1:0]     operation,
  input  logic [scbpa_pkg::SIZE_W-1:0]   request_size,
  input  logic [scbpa_pkg::CLASS_W-1:0]  free_class,
  input  logic [scbpa_pkg::OFFSET_W-1:0] free_offset,
  // command queue side
  output logic                           q_push,
  output scbpa_pkg::cmd_t                q_cmd,
  input  logic                           q_ready
);

  localparam logic [scbpa_pkg::CLASS_W-1:0] NC       = 3'(NUM_CLASSES);
  localparam logic [2:0]                    CFG_LAST = 3'(scbpa_pkg::MAX_CLASSES - 1);

  logic [scbpa_pkg::SIZE_W-1:0]  bsize [scbpa_pkg::MAX_CLASSES];
  logic                          fit_found;
  logic [scbpa_pkg::CLASS_W-1:0] fit_cls;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign q_push    = in_valid && q_ready;

  // Block size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < scbpa_pkg::MAX_CLASSES; c++) begin
        bsize[c] <= scbpa_pkg::reset_size(c);
      end
    end else if (cfg_valid && cfg_index <= CFG_LAST) begin
      bsize[cfg_index] <= cfg_data;
    end
  end

  // First class in index order that holds the request
  always_comb begin
    fit_found = 1'b0;
    fit_cls   = '0;
    for (int c = scbpa_pkg::MAX_CLASSES - 1; c >= 0; c--) begin
      if (c < NUM_CLASSES && bsize[c] >= request_size) begin
        fit_found = 1'b1;
        fit_cls   = 3'(c);
      end
    end
  end

  // Build the command for the back end
  always_comb begin
    q_cmd        = '0;
    q_cmd.foff   = free_offset;
    q_cmd.kind   = scbpa_pkg::K_REPLY;
    q_cmd.status = scbpa_pkg::ST_OK;
    q_cmd.cls    = scbpa_pkg::NO_CLASS;
    unique case (operation)
      scbpa_pkg::OP_ALLOC: begin
        if (fit_found) begin
          q_cmd.kind   = scbpa_pkg::K_ALLOC;
          q_cmd.cls    = fit_cls;
          q_cmd.stride = scbpa_pkg::stride_of(bsize[fit_cls]);
        end else begin
          q_cmd.status = scbpa_pkg::ST_TOO_LARGE;
        end
      end
      scbpa_pkg::OP_FREE: begin
        if (free_class < NC) begin
          q_cmd.kind   = scbpa_pkg::K_FREE;
          q_cmd.cls    = free_class;
          q_cmd.stride = scbpa_pkg::stride_of(bsize[free_class]);
        end else begin
          q_cmd.status = scbpa_pkg::ST_NO_MATCH;
        end
      end
      scbpa_pkg::OP_CLEAR: begin
        q_cmd.kind = scbpa_pkg::K_CLEAR;
      end
      default: begin
        q_cmd.kind = scbpa_pkg::K_REPLY;
      end
    endcase
  end

endmodule

// ===== hdl/scbpa_fifo.sv =====
// Short command queue between front and back end.
module scbpa_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scbpa_pkg::cmd_t push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output scbpa_pkg::cmd_t pop_cmd,
  output logic            pop_valid
);

  localparam int PTR_W = $clog2(scbpa_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(scbpa_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(scbpa_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(scbpa_pkg::Q_DEPTH);

  scbpa_pkg::cmd_t  entry [scbpa_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hdl/scbpa_back.sv =====
// Back end: slot bitmap, lowest-free search, offset scan for free, result register.
module scbpa_back #(
  parameter int SLOTS_SMALL  = 20,
  parameter int SLOTS_MEDIUM = 10,
  parameter int SLOTS_LARGE  = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  scbpa_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output scbpa_pkg::res_t out_res
);

  localparam int CW = scbpa_pkg::CLASS_W;
  localparam int SW = scbpa_pkg::SLOT_W;
  localparam int OW = scbpa_pkg::OFFSET_W;
  localparam int TW = scbpa_pkg::STRIDE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  // Highest slot index of a class
  function automatic logic [SW-1:0] last_slot(input logic [CW-1:0] c);
    int n;
    if (int'(c) < scbpa_pkg::SMALL_END)       n = SLOTS_SMALL;
    else if (int'(c) < scbpa_pkg::MEDIUM_END) n = SLOTS_MEDIUM;
    else                                      n = SLOTS_LARGE;
    if (n > scbpa_pkg::MAX_SLOTS) n = scbpa_pkg::MAX_SLOTS;
    return SW'(n - 1);
  endfunction

  logic [scbpa_pkg::MAX_CLASSES-1:0][scbpa_pkg::MAX_SLOTS-1:0] used;
  logic [1:0]          state;
  logic [CW-1:0]       r_cls;
  logic [TW-1:0]       r_stride;
  logic [OW-1:0]       r_foff;
  logic [SW-1:0]       r_slot;
  logic                r_found;
  logic [SW-1:0]       r_last;
  logic [SW-1:0]       cnt;
  logic [OW-1:0]       off;
  logic                out_free;
  logic [SW-1:0]       q_last;
  logic [scbpa_pkg::MAX_SLOTS-1:0] free_vec;
  logic                enc_found;
  logic [SW-1:0]       enc_slot;
  logic [SW+TW-1:0]    prod;
  logic [OW-1:0]       alloc_off;
  logic                hit;

  assign out_free  = !out_valid || out_ready;
  assign q_last    = last_slot(q_cmd.cls);
  assign prod      = {{TW{1'b0}}, r_slot} * {{SW{1'b0}}, r_stride};
  assign alloc_off = prod[OW-1:0] + scbpa_pkg::HDR_BYTES;
  assign hit       = (off == r_foff);

  // Take a command when its work can start
  always_comb begin
    q_pop = 1'b0;
    if (state == S_IDLE && q_valid) begin
      q_pop = (q_cmd.kind == scbpa_pkg::K_ALLOC) || (q_cmd.kind == scbpa_pkg::K_FREE)
              || out_free;
    end
  end

  // Lowest free slot of the queued class
  always_comb begin
    for (int i = 0; i < scbpa_pkg::MAX_SLOTS; i++) begin
      free_vec[i] = !used[q_cmd.cls][i] && (SW'(i) <= q_last);
    end
    enc_found = 1'b0;
    enc_slot  = '0;
    for (int i = scbpa_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        enc_found = 1'b1;
        enc_slot  = SW'(i);
      end
    end
  end

  // Sequencer, bitmap and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.kind)
              scbpa_pkg::K_ALLOC: begin
                r_cls    <= q_cmd.cls;
                r_stride <= q_cmd.stride;
                r_slot   <= enc_slot;
                r_found  <= enc_found;
                if (enc_found) begin
                  used[q_cmd.cls][enc_slot] <= 1'b1;
                end
                state <= S_ALLOC;
              end
              scbpa_pkg::K_FREE: begin
                r_cls    <= q_cmd.cls;
                r_stride <= q_cmd.stride;
                r_foff   <= q_cmd.foff;
                r_last   <= q_last;
                cnt      <= '0;
                off      <= scbpa_pkg::HDR_BYTES;
                state    <= S_SCAN;
              end
              scbpa_pkg::K_CLEAR: begin
                used      <= '0;
                out_valid <= 1'b1;
                out_res   <= '{block_offset: '0, slot_index: '0,
                               class_id: scbpa_pkg::NO_CLASS, status: scbpa_pkg::ST_OK};
              end
              default: begin
                out_valid <= 1'b1;
                out_res   <= '{block_offset: '0, slot_index: '0,
                               class_id: q_cmd.cls, status: q_cmd.status};
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (r_found) begin
              out_res <= '{block_offset: alloc_off, slot_index: r_slot,
                           class_id: r_cls, status: scbpa_pkg::ST_OK};
            end else begin
              out_res <= '{block_offset: '0, slot_index: '0,
                           class_id: r_cls, status: scbpa_pkg::ST_FULL};
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (out_free) begin
              out_valid <= 1'b1;
              if (used[r_cls][cnt]) begin
                used[r_cls][cnt] <= 1'b0;
                out_res <= '{block_offset: off, slot_index: cnt,
                             class_id: r_cls, status: scbpa_pkg::ST_OK};
              end else begin
                out_res <= '{block_offset: off, slot_index: cnt,
                             class_id: r_cls, status: scbpa_pkg::ST_ALREADY_FREE};
              end
              state <= S_IDLE;
            end
          end else if (cnt == r_last) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_res   <= '{block_offset: '0, slot_index: '0,
                             class_id: r_cls, status: scbpa_pkg::ST_NO_MATCH};
              state     <= S_IDLE;
            end
          end else begin
            cnt <= cnt + 1'b1;
            off <= off + {{(OW-TW){1'b0}}, r_stride};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= r_last))
    else $error("free scan ran past the last slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.kind == scbpa_pkg::K_CLEAR) |=> (used == '0))
    else $error("clear left a slot in use");

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC && r_found) |-> used[r_cls][r_slot])
    else $error("allocated slot not marked in use");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_pop)
    else $error("command taken while back end busy");
`endif

endmodule

// ===== hdl/size_class_block_pool_allocator.sv =====
// The back end takes one command at a time from the queue. A free scans the slots in order,
//   one slot per cycle, up to the matched slot (the last slot when none matches).
// Throughput: one item per cycle into the queue while the queue has room; an allocate does
//   the lowest-free search, then the offset multiply.
// Reset (rst, synchronous): all slots free, block sizes 64, 128, 512, 1024, 10240, 102400,
//   307200, queue and result register empty.
module size_class_block_pool_allocator #(
  parameter int SLOTS_SMALL  = 20,
  parameter int SLOTS_MEDIUM = 10,
  parameter int SLOTS_LARGE  = 2,
  parameter int NUM_CLASSES  = 7
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // operation[1:0], request_size[21:2],
                                     // free_class[24:22], free_offset[48:25], zero fill
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[2:0], class_id[5:3], slot_index[10:6],
                                     // block_offset[34:11], zero fill
);

  scbpa_pkg::cmd_t push_cmd;
  scbpa_pkg::cmd_t pop_cmd;
  scbpa_pkg::res_t res;
  logic            push;
  logic            push_ready;
  logic            pop;
  logic            pop_valid;

  // Classification
  scbpa_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .operation    (s_axis_tdata[1:0]),
    .request_size (s_axis_tdata[21:2]),
    .free_class   (s_axis_tdata[24:22]),
    .free_offset  (s_axis_tdata[48:25]),
    .q_push       (push),
    .q_cmd        (push_cmd),
    .q_ready      (push_ready)
  );

  // Command queue
  scbpa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  // Execution
  scbpa_back #(
    .SLOTS_SMALL  (SLOTS_SMALL),
    .SLOTS_MEDIUM (SLOTS_MEDIUM),
    .SLOTS_LARGE  (SLOTS_LARGE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {5'd0, res.block_offset, res.slot_index, res.class_id, res.status};

endmodule
